FILE: rtl/core/wrte_pkg.sv
// shared types and constants for the weighted rms trace error unit
`default_nettype none
package wrte_pkg;
    localparam int SUM_W   = 64;
    localparam int TOT_W   = 32;
    localparam int IDX_W   = 10;
    localparam int SMP_W   = 16;
    localparam int ROOT_W  = 32;

    // commands from controller to datapath
    typedef struct packed {
        logic load;      // register input word
        logic square;    // register the squared difference
        logic accum;     // add term into sum and bump count
        logic div_start; // latch sum and count into the divider
        logic div_step;  // one restoring divide step
        logic sqrt_start;
        logic sqrt_step; // one root step
        logic close;     // add root to total, clear segment state
        logic emit;      // load output register, clear total and flag, bump organism index
    } wrte_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic seg_close;
        logic org_close;
    } wrte_stat_t;
endpackage
`default_nettype wire

FILE: rtl/core/weighted_rms_trace_error_unit.sv
// top level of the weighted rms trace error unit
// a plain sample passes the load, square and accumulate states; a segment close adds
//   the divide, root and close states; an organism close adds emit, which waits while busy
// a new word is taken only in the idle state, once the previous word has passed the
//   registered square, the multiply-accumulate and any close steps
// reset: aresetn clears sums, count, total, organism index, flag and valid
`default_nettype none
module weighted_rms_trace_error_unit
    import wrte_pkg::*;
#(
    parameter int MAX_SEGMENT_SAMPLES = 65536,
    parameter int MAX_ORGANISMS       = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // reference_mv [15:0], candidate_mv [31:16], sample_weight [47:32]
    input  wire logic [47:0] s_tdata,
    // segment_end [0], organism_end [1]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // error_total [31:0], organism_index [41:32], zero pad [47:42]
    output logic [47:0]      m_tdata,
    // overflowed [0]
    output logic             m_tuser
);
    localparam int CNT_W = $clog2(MAX_SEGMENT_SAMPLES + 1);
    localparam int ORG_W = (MAX_ORGANISMS > 1) ? $clog2(MAX_ORGANISMS) : 1;

    wrte_cmd_t        cmd;
    wrte_stat_t       stat;
    logic             in_fire;
    logic             m_valid_reg;
    logic [TOT_W-1:0] res_total;
    logic [IDX_W-1:0] res_index;
    logic             res_ovf;

    assign in_fire = s_tvalid & s_tready;

    wrte_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .out_busy (m_valid_reg & ~m_tready),
        .stat     (stat),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    wrte_dp #(
        .MAX_SEGMENT_SAMPLES (MAX_SEGMENT_SAMPLES),
        .MAX_ORGANISMS       (MAX_ORGANISMS),
        .CNT_W               (CNT_W),
        .ORG_W               (ORG_W)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .reference_mv  (s_tdata[15:0]),
        .candidate_mv  (s_tdata[31:16]),
        .sample_weight (s_tdata[47:32]),
        .segment_end   (s_tuser[0]),
        .organism_end  (s_tuser[1]),
        .cmd           (cmd),
        .stat          (stat),
        .res_total     (res_total),
        .res_index     (res_index),
        .res_ovf       (res_ovf)
    );

    // output word holds until taken; emit only fires when the slot is free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, res_index, res_total};
    assign m_tuser  = res_ovf;

    // never emit over a word that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !(m_valid_reg && !m_tready))
        else $error("result overwritten");

    // input only taken when the controller is idle, never with a busy command
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |-> !(cmd.div_step || cmd.sqrt_step || cmd.close || cmd.emit))
        else $error("input taken while busy");

    // a waiting result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");
endmodule
`default_nettype wire

FILE: rtl/core/wrte_ctrl.sv
// controller state machine for the weighted rms trace error unit
`default_nettype none
module wrte_ctrl
    import wrte_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_fire,
    input  wire logic       out_busy,
    input  wire wrte_stat_t stat,
    output logic            in_ready,
    output wrte_cmd_t       cmd
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_SQ, ST_ACC, ST_DIV, ST_SQRT, ST_CLOSE, ST_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_fire) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                cmd.square = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.accum = 1'b1;
                if (stat.seg_close) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (cnt_reg == 7'd0) begin
                    cmd.div_start = 1'b1;
                    cnt_next = 7'd1;
                end else begin
                    cmd.div_step = 1'b1;
                    cnt_next = cnt_reg + 7'd1;
                    if (cnt_reg == 7'd64) begin
                        cnt_next   = 7'd0;
                        state_next = ST_SQRT;
                    end
                end
            end
            ST_SQRT: begin
                if (cnt_reg == 7'd0) begin
                    cmd.sqrt_start = 1'b1;
                    cnt_next = 7'd1;
                end else begin
                    cmd.sqrt_step = 1'b1;
                    cnt_next = cnt_reg + 7'd1;
                    if (cnt_reg == 7'd32) begin
                        cnt_next   = 7'd0;
                        state_next = ST_CLOSE;
                    end
                end
            end
            ST_CLOSE: begin
                cmd.close = 1'b1;
                state_next = stat.org_close ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (!out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/wrte_dp.sv
// datapath: term multiply, accumulate, serial divide, serial root, totals
`default_nettype none
module wrte_dp
    import wrte_pkg::*;
#(
    parameter int MAX_SEGMENT_SAMPLES = 65536,
    parameter int MAX_ORGANISMS       = 1024,
    parameter int CNT_W               = 21,
    parameter int ORG_W               = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic signed [SMP_W-1:0] reference_mv,
    input  wire logic signed [SMP_W-1:0] candidate_mv,
    input  wire logic [SMP_W-1:0]  sample_weight,
    input  wire logic              segment_end,
    input  wire logic              organism_end,
    input  wire wrte_cmd_t         cmd,
    output wrte_stat_t             stat,
    output logic [TOT_W-1:0]       res_total,
    output logic [IDX_W-1:0]       res_index,
    output logic                   res_ovf
);
    logic [16:0]       mag_reg;
    logic [33:0]       sq_reg;
    logic [SMP_W-1:0]  w_reg;
    logic              seg_reg, org_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [TOT_W-1:0]  tot_reg;
    logic [ORG_W-1:0]  org_cnt_reg;
    logic              ovf_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W:0]    rem_reg;
    logic [CNT_W-1:0]  dvs_reg;
    logic [SUM_W-1:0]  rad_reg;
    logic [SUM_W+1:0]  srem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic signed [16:0] diff;
    logic [33:0]        sq;
    logic [49:0]        term;
    logic [SUM_W:0]     sum_add;
    logic [CNT_W:0]     rem_sh;
    logic [SUM_W+1:0]   srem_sh, strial;
    logic [TOT_W:0]     tot_add;

    assign diff    = 17'(reference_mv) - 17'(candidate_mv);
    assign sq      = 34'(mag_reg) * 34'(mag_reg);
    assign term    = sq_reg * 50'(w_reg);
    assign sum_add = {1'b0, sum_reg} + 65'(term);
    assign rem_sh  = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};
    assign srem_sh = {srem_reg[SUM_W-1:0], rad_reg[SUM_W-1:SUM_W-2]};
    assign strial  = 66'({root_reg, 2'b01});
    assign tot_add = {1'b0, tot_reg} + 33'(root_reg);

    assign stat.seg_close = seg_reg | org_reg;
    assign stat.org_close = org_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mag_reg <= diff[16] ? 17'(-diff) : 17'(diff);
            w_reg   <= sample_weight;
            seg_reg <= segment_end;
            org_reg <= organism_end;
        end
        if (cmd.square) begin
            sq_reg <= sq;
        end
        if (cmd.div_start) begin
            quo_reg <= sum_reg;
            rem_reg <= '0;
            dvs_reg <= (cnt_reg == '0) ? CNT_W'(1) : cnt_reg;
        end else if (cmd.div_step) begin
            if (rem_sh >= {1'b0, dvs_reg}) begin
                rem_reg <= rem_sh - {1'b0, dvs_reg};
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
        if (cmd.sqrt_start) begin
            rad_reg  <= quo_reg;
            srem_reg <= '0;
            root_reg <= '0;
        end else if (cmd.sqrt_step) begin
            rad_reg <= {rad_reg[SUM_W-3:0], 2'b00};
            if (srem_sh >= strial) begin
                srem_reg <= srem_sh - strial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                srem_reg <= srem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.emit) begin
            res_total <= tot_reg;
            res_index <= IDX_W'(org_cnt_reg);
            res_ovf   <= ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            cnt_reg     <= '0;
            tot_reg     <= '0;
            org_cnt_reg <= '0;
            ovf_reg     <= 1'b0;
        end else begin
            if (cmd.accum) begin
                if (sum_add[SUM_W]) begin
                    sum_reg <= '1;
                    ovf_reg <= 1'b1;
                end else begin
                    sum_reg <= sum_add[SUM_W-1:0];
                end
                if (cnt_reg < CNT_W'(MAX_SEGMENT_SAMPLES)) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.close) begin
                sum_reg <= '0;
                cnt_reg <= '0;
                if (tot_add[TOT_W]) begin
                    tot_reg <= '1;
                    ovf_reg <= 1'b1;
                end else begin
                    tot_reg <= tot_add[TOT_W-1:0];
                end
            end
            if (cmd.emit) begin
                tot_reg <= '0;
                ovf_reg <= 1'b0;
                org_cnt_reg <= (org_cnt_reg >= ORG_W'(MAX_ORGANISMS - 1)) ? '0
                             : org_cnt_reg + ORG_W'(1);
            end
        end
    end
endmodule
`default_nettype wire
